// ===== hw/rtl/circular_list_with_cursor_macros.svh =====
// Assertion macros shared by the checker of the cursor ring.
// Each macro expands to one labeled concurrent assertion with an async-reset disable.
`ifndef CIRCULAR_LIST_WITH_CURSOR_MACROS_SVH
`define CIRCULAR_LIST_WITH_CURSOR_MACROS_SVH

// Same-cycle implication.
`define CLWC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CLWC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/clwc_pkg.sv =====
// Shared types and constants for the circular list with cursor.
// No dependencies; imported by the sequencer, the free stack and the top level.
`timescale 1ns / 1ps

package clwc_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int KIND_W          = 3;

	typedef enum logic [KIND_W-1:0] {
		OP_INS_AFTER  = 3'd0,
		OP_INS_BEFORE = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_NEXT       = 3'd3,
		OP_PREV       = 3'd4,
		OP_OVERWRITE  = 3'd5,
		OP_ZERO_ALL   = 3'd6,
		OP_CLEAR      = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS1,
		S_INS2,
		S_LOAD,
		S_ZERO,
		S_RESP
	} state_t;

	// Free stack commands issued by the sequencer.
	typedef struct packed {
		logic pop;
		logic push;
		logic clear;
	} fs_ctrl_t;

	// Result flags; is_empty sits in the low bit.
	typedef struct packed {
		logic error;
		logic is_empty;
	} flags_t;

endpackage

// ===== hw/rtl/clwc_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies; used for the slot value, link and free stack memories.
`timescale 1ns / 1ps

module clwc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/clwc_free_stack.sv =====
// Free slot stack of the ring, kept in one RAM with a low-water mark.
// Depends on clwc_pkg and clwc_ram.
`timescale 1ns / 1ps

module clwc_free_stack #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  clwc_pkg::fs_ctrl_t          ctrl,
	input  logic [$clog2(CAPACITY)-1:0] push_slot,
	output logic [$clog2(CAPACITY)-1:0] pop_slot
);

	import clwc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] top_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] top_dec;
	logic [CNT_W-1:0] fresh_slot;
	logic [IDX_W-1:0] ram_rdata;

	// Entries below the low-water mark still hold their initial contents,
	// entry i holding CAPACITY-1-i, so they are never stored after a clear.
	assign top_dec    = top_q - CNT_W'(1);
	assign fresh_slot = CAP_C - top_q;
	assign pop_slot   = (top_q == lo_q) ? fresh_slot[IDX_W-1:0] : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CAP_C;
			lo_q  <= CAP_C;
		end else if (ctrl.clear) begin
			top_q <= CAP_C;
			lo_q  <= CAP_C;
		end else if (ctrl.pop) begin
			top_q <= top_dec;
			if (top_q == lo_q) begin
				lo_q <= top_dec;
			end
		end else if (ctrl.push) begin
			top_q <= top_q + CNT_W'(1);
		end
	end

	clwc_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(IDX_W)
	) u_stack_ram (
		.clk  (clk),
		.we   (ctrl.push),
		.waddr(top_q[IDX_W-1:0]),
		.wdata(push_slot),
		.raddr(top_dec[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

endmodule

// ===== hw/rtl/clwc_seq.sv =====
// Operation sequencer of the ring: slot value and link memories plus the cursor registers.
// Depends on clwc_pkg and clwc_ram.
`timescale 1ns / 1ps

module clwc_seq #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  clwc_pkg::kind_t                  kind,
	input  logic [VALUE_WIDTH-1:0]           value_in,
	input  logic                             out_ok,
	output logic                             res_load,
	output logic [VALUE_WIDTH-1:0]           res_value,
	output logic [$clog2(CAPACITY+1)-1:0]    res_count,
	output clwc_pkg::flags_t                 res_flags,
	output clwc_pkg::fs_ctrl_t               fs_ctrl,
	output logic [$clog2(CAPACITY)-1:0]      push_slot,
	input  logic [$clog2(CAPACITY)-1:0]      pop_slot
);

	import clwc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	state_t state_q, state_nxt, disp_nxt;

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       cursor_q;
	logic [VALUE_WIDTH-1:0] cur_val_q;
	logic [IDX_W-1:0]       cur_next_q;
	logic [IDX_W-1:0]       cur_prev_q;
	logic [IDX_W-1:0]       slot_q;
	logic [VALUE_WIDTH-1:0] val_q;
	kind_t                  op_q;
	logic                   err_q;
	logic                   fix_q;
	logic [CNT_W-1:0]       k_q;

	logic disp, acc, empty, full, single, disp_err, zero_last, after_q;

	logic                   val_we, next_we, prev_we;
	logic [IDX_W-1:0]       val_waddr, next_waddr, prev_waddr, rd_addr;
	logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
	logic [IDX_W-1:0]       next_wdata, prev_wdata, next_rdata, prev_rdata;

	assign disp      = (state_q == S_IDLE) || ((state_q == S_RESP) && out_ok);
	assign acc       = disp && in_valid;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CAP_C);
	assign single    = (count_q == CNT_W'(1));
	assign zero_last = (k_q == (count_q - CNT_W'(1)));
	assign after_q   = (op_q == OP_INS_AFTER);

	always_comb begin : p_decode
		disp_err = 1'b0;
		disp_nxt = S_RESP;
		unique case (kind) inside
			OP_INS_AFTER, OP_INS_BEFORE: begin
				disp_err = full;
				disp_nxt = full ? S_RESP : S_INS1;
			end
			OP_REMOVE: begin
				disp_err = empty;
				disp_nxt = (empty || single) ? S_RESP : S_LOAD;
			end
			OP_NEXT, OP_PREV: begin
				disp_err = empty;
				disp_nxt = empty ? S_RESP : S_LOAD;
			end
			OP_OVERWRITE: begin
				disp_err = empty;
			end
			OP_ZERO_ALL: begin
				disp_err = empty;
				disp_nxt = (empty || single) ? S_RESP : S_ZERO;
			end
			OP_CLEAR: begin
				disp_err = 1'b0;
			end
		endcase
	end

	always_comb begin : p_next_state
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if (disp) begin
					state_nxt = in_valid ? disp_nxt : S_IDLE;
				end
			end
			S_INS1: state_nxt = empty ? S_RESP : S_INS2;
			S_INS2, S_LOAD: state_nxt = S_RESP;
			S_ZERO: begin
				if (zero_last) begin
					state_nxt = S_RESP;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin : p_outputs
		in_ready   = disp;
		res_load   = (state_q == S_RESP) && out_ok;
		fs_ctrl    = '0;
		push_slot  = cursor_q;
		val_we     = 1'b0;
		val_waddr  = cursor_q;
		val_wdata  = val_q;
		next_we    = 1'b0;
		next_waddr = cursor_q;
		next_wdata = slot_q;
		prev_we    = 1'b0;
		prev_waddr = cursor_q;
		prev_wdata = slot_q;
		rd_addr    = (state_q == S_ZERO) ? next_rdata : cursor_q;

		if (acc) begin
			unique case (kind) inside
				OP_INS_AFTER, OP_INS_BEFORE: begin
					// The free stack read is issued every cycle; nothing to do here.
				end
				OP_REMOVE: begin
					rd_addr = cur_next_q;
					if (!empty) begin
						fs_ctrl.push = 1'b1;
						if (!single) begin
							next_we    = 1'b1;
							next_waddr = cur_prev_q;
							next_wdata = cur_next_q;
							prev_we    = 1'b1;
							prev_waddr = cur_next_q;
							prev_wdata = cur_prev_q;
						end
					end
				end
				OP_NEXT: rd_addr = cur_next_q;
				OP_PREV: rd_addr = cur_prev_q;
				OP_OVERWRITE: begin
					if (!empty) begin
						val_we    = 1'b1;
						val_wdata = value_in;
					end
				end
				OP_ZERO_ALL: begin
					if (!empty) begin
						val_we    = 1'b1;
						val_wdata = '0;
					end
				end
				OP_CLEAR: fs_ctrl.clear = 1'b1;
			endcase
		end

		unique case (state_q)
			S_INS1: begin
				fs_ctrl.pop = 1'b1;
				val_we      = 1'b1;
				val_waddr   = pop_slot;
				val_wdata   = val_q;
				next_we     = 1'b1;
				next_waddr  = pop_slot;
				prev_we     = 1'b1;
				prev_waddr  = pop_slot;
				if (empty) begin
					next_wdata = pop_slot;
					prev_wdata = pop_slot;
				end else if (after_q) begin
					next_wdata = cur_next_q;
					prev_wdata = cursor_q;
				end else begin
					next_wdata = cursor_q;
					prev_wdata = cur_prev_q;
				end
			end
			S_INS2: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				if (after_q) begin
					next_waddr = cursor_q;
					prev_waddr = cur_next_q;
				end else begin
					next_waddr = cur_prev_q;
					prev_waddr = cursor_q;
				end
			end
			S_ZERO: begin
				val_we    = 1'b1;
				val_waddr = next_rdata;
				val_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (acc) begin
				unique case (kind) inside
					OP_REMOVE: begin
						if (!empty) begin
							count_q  <= count_q - CNT_W'(1);
							cursor_q <= single ? '0 : cur_next_q;
						end
					end
					OP_NEXT: begin
						if (!empty) begin
							cursor_q <= cur_next_q;
						end
					end
					OP_PREV: begin
						if (!empty) begin
							cursor_q <= cur_prev_q;
						end
					end
					OP_CLEAR: begin
						count_q  <= '0;
						cursor_q <= '0;
					end
					OP_INS_AFTER, OP_INS_BEFORE, OP_OVERWRITE, OP_ZERO_ALL: begin
					end
				endcase
			end
			if (state_q == S_INS1 && empty) begin
				cursor_q <= pop_slot;
				count_q  <= count_q + CNT_W'(1);
			end
			if (state_q == S_INS2) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Operation registers and the cached copy of the cursor entry: value and both links.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= kind;
			val_q <= value_in;
			err_q <= disp_err;
			fix_q <= (kind == OP_REMOVE);
			k_q   <= CNT_W'(1);
			if (kind == OP_OVERWRITE && !empty) begin
				cur_val_q <= value_in;
			end
			if (kind == OP_ZERO_ALL && !empty) begin
				cur_val_q <= '0;
			end
		end
		unique case (state_q)
			S_INS1: begin
				slot_q <= pop_slot;
				if (empty) begin
					cur_val_q  <= val_q;
					cur_next_q <= pop_slot;
					cur_prev_q <= pop_slot;
				end
			end
			S_INS2: begin
				// With a single entry both cursor links point at the new slot.
				if (after_q) begin
					cur_next_q <= slot_q;
					if (cur_next_q == cursor_q) begin
						cur_prev_q <= slot_q;
					end
				end else begin
					cur_prev_q <= slot_q;
					if (cur_prev_q == cursor_q) begin
						cur_next_q <= slot_q;
					end
				end
			end
			S_LOAD: begin
				cur_val_q <= val_rdata;
				if (fix_q) begin
					// After a removal the read raced the relinking writes, so the
					// previous link is already known and a two-entry ring closes on itself.
					cur_next_q <= (cursor_q == cur_prev_q) ? cursor_q : next_rdata;
				end else begin
					cur_next_q <= next_rdata;
					cur_prev_q <= prev_rdata;
				end
			end
			S_ZERO: k_q <= k_q + CNT_W'(1);
			default: begin
			end
		endcase
	end

	assign res_value          = empty ? '0 : cur_val_q;
	assign res_count          = count_q;
	assign res_flags.is_empty = empty;
	assign res_flags.error    = err_q;

	clwc_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_WIDTH)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.raddr(rd_addr),
		.rdata(val_rdata)
	);

	clwc_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(IDX_W)
	) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(rd_addr),
		.rdata(next_rdata)
	);

	clwc_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(IDX_W)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(rd_addr),
		.rdata(prev_rdata)
	);

endmodule

// ===== hw/rtl/circular_list_with_cursor.sv =====
// Top level of the circular list with cursor: stream ports and the result register.
// Depends on clwc_pkg, clwc_seq and clwc_free_stack.
`timescale 1ns / 1ps

// Circular doubly linked ring of CAPACITY signed words with a cursor. Each input beat
// carries an operation in s_tuser and a value in s_tdata, and produces exactly one result
// beat with the cursor value, the entry count and the empty and error flags. Values and
// links live in synchronous RAMs with registered read data, and free slots sit on a
// RAM stack with a low-water mark, so there is no clearing pass after reset or clear.
// Overwrite, clear, removing the only entry and every illegal operation go straight to
// the result; other removes, next and prev first pass a load state, in which the one
// link-memory read refills the cursor registers; both inserts take the slot popped from
// the free stack and write the new entry, then write the neighbour links in a second
// state, and an insert into an empty ring needs only the first; zero-all walks the ring
// and zeroes the entries as it follows one next link read per cycle. The result register
// lets the next beat be accepted while a result still waits; the block stalls only when
// a new result is ready and the old one is not taken.
module circular_list_with_cursor #(
	parameter int CAPACITY    = clwc_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = clwc_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// value_in
	input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// kind
	input  logic [clwc_pkg::KIND_W-1:0]           s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// cur_value, count, zero padding
	output logic [((VALUE_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	// is_empty, error
	output logic [1:0]                            m_tuser
);

	import clwc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OUT_W = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [CNT_W-1:0]       out_count_q;
	flags_t                 out_flags_q;

	logic                   out_ok;
	logic                   res_load;
	logic [VALUE_WIDTH-1:0] res_value;
	logic [CNT_W-1:0]       res_count;
	flags_t                 res_flags;
	fs_ctrl_t               fs_ctrl;
	logic [IDX_W-1:0]       push_slot;
	logic [IDX_W-1:0]       pop_slot;

	assign out_ok = !out_valid_q || m_tready;

	clwc_seq #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (kind_t'(s_tuser)),
		.value_in (s_tdata[VALUE_WIDTH-1:0]),
		.out_ok   (out_ok),
		.res_load (res_load),
		.res_value(res_value),
		.res_count(res_count),
		.res_flags(res_flags),
		.fs_ctrl  (fs_ctrl),
		.push_slot(push_slot),
		.pop_slot (pop_slot)
	);

	clwc_free_stack #(
		.CAPACITY(CAPACITY)
	) u_free_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (fs_ctrl),
		.push_slot(push_slot),
		.pop_slot (pop_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_value_q <= res_value;
			out_count_q <= res_count;
			out_flags_q <= res_flags;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_count_q, out_value_q});
	assign m_tuser  = out_flags_q;

endmodule

// ===== hw/rtl/clwc_checker.sv =====
// Port-level checker for the circular list with cursor, bound to the top level.
// Depends on circular_list_with_cursor_macros.svh.
`timescale 1ns / 1ps

`include "circular_list_with_cursor_macros.svh"

module clwc_checker #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((VALUE_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	input logic [1:0]                            m_tuser
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]       mon_count;
	logic [VALUE_WIDTH-1:0] mon_value;
	logic                   mon_accept;

	assign mon_count  = m_tdata[VALUE_WIDTH +: CNT_W];
	assign mon_value  = m_tdata[VALUE_WIDTH-1:0];
	assign mon_accept = s_tvalid && s_tready;

	`CLWC_ASSERT_NXT(a_result_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed or vanished")
	`CLWC_ASSERT_IMP(a_empty_flag, clk, arst_n, m_tvalid, m_tuser[0] == (mon_count == '0), "empty flag disagrees with entry count")
	`CLWC_ASSERT_IMP(a_empty_value, clk, arst_n, m_tvalid && m_tuser[0], mon_value == '0, "empty ring reports a nonzero cursor value")
	`CLWC_ASSERT_IMP(a_count_range, clk, arst_n, m_tvalid, mon_count <= CNT_W'(CAPACITY), "entry count exceeds capacity")
	`CLWC_ASSERT_IMP(a_idle_after_reset, clk, arst_n, !$past(arst_n), !m_tvalid && (!s_tvalid || mon_accept), "block not idle and ready right after reset")

endmodule

bind circular_list_with_cursor clwc_checker #(
	.CAPACITY   (CAPACITY),
	.VALUE_WIDTH(VALUE_WIDTH)
) u_clwc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
